### rtl/core/olir_pkg.sv
`timescale 1ns / 1ps
// shared types, sizes and codes for the ordered list insert/remove block
// no dependencies; used by the interfaces, the cell and the top level

package olir_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int POS_W       = 7;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // operation codes
    localparam logic [1:0] OP_APPEND     = 2'd0;
    localparam logic [1:0] OP_INSERT_AT  = 2'd1;
    localparam logic [1:0] OP_REMOVE_VAL = 2'd2;
    localparam logic [1:0] OP_REMOVE_AT  = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd3;

    // per-cell update commands
    localparam logic [1:0] CMD_HOLD       = 2'd0;
    localparam logic [1:0] CMD_INSERT     = 2'd1;
    localparam logic [1:0] CMD_REMOVE_VAL = 2'd2;
    localparam logic [1:0] CMD_REMOVE_AT  = 2'd3;

    // search request broadcast to all cells when a transaction is taken
    typedef struct packed {
        logic                   en;
        logic [VALUE_WIDTH-1:0] value;
        logic [POS_W-1:0]       pos;
        logic [CNT_W-1:0]       count;
    } probe_t;

    // update command broadcast to all cells
    typedef struct packed {
        logic [1:0]             kind;
        logic [VALUE_WIDTH-1:0] value;
        logic [POS_W-1:0]       pos;
    } cmd_t;

    // data handed from cell to cell along the row
    typedef struct packed {
        logic                   found;
        logic [VALUE_WIDTH-1:0] picked;
    } chain_t;

endpackage

### rtl/core/olir_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and result transactions
// depends on olir_pkg for widths

interface olir_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     operation;
    logic [31:0]                    item_value;
    logic [olir_pkg::POS_W-1:0]     position;

    modport source (output valid, output operation, output item_value, output position,
                    input ready);
    modport sink   (input valid, input operation, input item_value, input position,
                    output ready);
endinterface

interface olir_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [31:0]                    removed_value;
    logic [olir_pkg::POS_W-1:0]     list_length;

    modport source (output valid, output status, output removed_value, output list_length,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input list_length,
                    output ready);
endinterface

### rtl/core/ordered_list_insert_remove_top.sv
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY entries held in a row of shifting cells.
// Results are registered in the output register; execute waits while it is full.
// A new request is taken only when idle; taking it registers every cell's compare,
// then execute resolves the first match along the row and shifts the cells.
// Reset: asynchronous, active low; clears the length and control, entries stay unset.

module ordered_list_insert_remove_top (
    input  logic        clk,
    input  logic        rst_n,
    olir_req_if.sink    item,
    olir_rsp_if.source  result
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                                   state_reg;
    logic                                   state_next;
    logic [1:0]                             op_reg;
    logic [olir_pkg::VALUE_WIDTH-1:0]       val_reg;
    logic [olir_pkg::POS_W-1:0]             pos_reg;
    logic [olir_pkg::CNT_W-1:0]             count_reg;
    logic [olir_pkg::CNT_W-1:0]             count_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [1:0]                             out_status_reg;
    logic [31:0]                            out_removed_reg;
    logic [olir_pkg::POS_W-1:0]             out_length_reg;

    logic                                   accept;
    logic                                   fire;
    logic [1:0]                             status;
    logic [olir_pkg::VALUE_WIDTH-1:0]       removed;
    olir_pkg::probe_t                       probe;
    olir_pkg::cmd_t                         cmd;
    olir_pkg::chain_t                       chain [olir_pkg::CAPACITY+1];
    logic [olir_pkg::VALUE_WIDTH-1:0]       cell_value [olir_pkg::CAPACITY];

    // handshake
    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign fire       = (state_reg == S_EXEC) && (!out_valid_reg || result.ready);

    // search request to the cells
    always_comb
    begin
        probe.en    = accept;
        probe.value = olir_pkg::VALUE_WIDTH'(item.item_value);
        probe.pos   = item.position;
        probe.count = count_reg;
    end

    // status of the pending transaction
    always_comb
    begin
        status = olir_pkg::STATUS_OK;
        case (op_reg)
            olir_pkg::OP_APPEND:
            begin
                if (int'(count_reg) >= olir_pkg::CAPACITY)
                begin
                    status = olir_pkg::STATUS_FULL;
                end
            end
            olir_pkg::OP_INSERT_AT:
            begin
                if (int'(pos_reg) > int'(count_reg))
                begin
                    status = olir_pkg::STATUS_BAD_INDEX;
                end
                else if (int'(count_reg) >= olir_pkg::CAPACITY)
                begin
                    status = olir_pkg::STATUS_FULL;
                end
            end
            olir_pkg::OP_REMOVE_VAL:
            begin
                if (!chain[olir_pkg::CAPACITY].found)
                begin
                    status = olir_pkg::STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                if (int'(pos_reg) >= int'(count_reg))
                begin
                    status = olir_pkg::STATUS_BAD_INDEX;
                end
            end
        endcase
    end

    // update command to the cells and new length
    always_comb
    begin
        cmd.kind   = olir_pkg::CMD_HOLD;
        cmd.value  = val_reg;
        cmd.pos    = pos_reg;
        count_next = count_reg;
        removed    = '0;
        if (fire && status == olir_pkg::STATUS_OK)
        begin
            case (op_reg)
                olir_pkg::OP_APPEND:
                begin
                    cmd.kind   = olir_pkg::CMD_INSERT;
                    cmd.pos    = olir_pkg::POS_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
                olir_pkg::OP_INSERT_AT:
                begin
                    cmd.kind   = olir_pkg::CMD_INSERT;
                    count_next = count_reg + 1'b1;
                end
                olir_pkg::OP_REMOVE_VAL:
                begin
                    cmd.kind   = olir_pkg::CMD_REMOVE_VAL;
                    count_next = count_reg - 1'b1;
                end
                default:
                begin
                    cmd.kind   = olir_pkg::CMD_REMOVE_AT;
                    count_next = count_reg - 1'b1;
                    removed    = chain[olir_pkg::CAPACITY].picked;
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= item.operation;
            val_reg <= olir_pkg::VALUE_WIDTH'(item.item_value);
            pos_reg <= item.position;
        end
        if (fire)
        begin
            out_status_reg  <= status;
            out_removed_reg <= 32'(removed);
            out_length_reg  <= olir_pkg::POS_W'(count_next);
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.removed_value = out_removed_reg;
    assign result.list_length   = out_length_reg;

    // row of cells
    assign chain[0] = '0;

    for (genvar i = 0; i < olir_pkg::CAPACITY; i++)
    begin : g_cell
        logic [olir_pkg::VALUE_WIDTH-1:0] left_value;
        logic [olir_pkg::VALUE_WIDTH-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_mid_l
            assign left_value = cell_value[i-1];
        end

        if (i == olir_pkg::CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_mid_r
            assign right_value = cell_value[i+1];
        end

        olir_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .index       (olir_pkg::CNT_W'(i)),
            .probe       (probe),
            .cmd         (cmd),
            .left_value  (left_value),
            .right_value (right_value),
            .chain_in    (chain[i]),
            .chain_out   (chain[i+1]),
            .value       (cell_value[i])
        );
    end

`ifndef ASSERT_OFF
    // length never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= olir_pkg::CAPACITY)
        else $error("list length above capacity");

    // a failed operation leaves the length alone
    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status != olir_pkg::STATUS_OK) |=> $stable(count_reg))
        else $error("length changed on failed operation");

    // a new result only comes out of the execute cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result without execute cycle");

    // length only changes in the execute cycle of a transaction
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(count_reg))
        else $error("length changed without a transaction");
`endif

endmodule

### rtl/core/olir_cell.sv
`timescale 1ns / 1ps
// one list cell: holds an entry, compares it, and shifts with its neighbors
// depends on olir_pkg

module olir_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [olir_pkg::CNT_W-1:0]          index,
    input  olir_pkg::probe_t                    probe,
    input  olir_pkg::cmd_t                      cmd,
    input  logic [olir_pkg::VALUE_WIDTH-1:0]    left_value,
    input  logic [olir_pkg::VALUE_WIDTH-1:0]    right_value,
    input  olir_pkg::chain_t                    chain_in,
    output olir_pkg::chain_t                    chain_out,
    output logic [olir_pkg::VALUE_WIDTH-1:0]    value
);

    logic [olir_pkg::VALUE_WIDTH-1:0] value_reg;
    logic [olir_pkg::VALUE_WIDTH-1:0] value_next;
    logic                             match_reg;
    logic                             match_next;
    logic                             pick_reg;
    logic                             pick_next;

    // compare and index hit, captured when a transaction is taken
    always_comb
    begin
        match_next = match_reg;
        pick_next  = pick_reg;
        if (probe.en)
        begin
            match_next = (value_reg == probe.value) && (int'(index) < int'(probe.count));
            pick_next  = (int'(index) == int'(probe.pos));
        end
    end

    // first-match flag and picked entry ripple along the row
    always_comb
    begin
        chain_out.found  = chain_in.found | match_reg;
        chain_out.picked = chain_in.picked | (pick_reg ? value_reg : '0);
    end

    // entry update: load, take left neighbor, or take right neighbor
    always_comb
    begin
        value_next = value_reg;
        case (cmd.kind)
            olir_pkg::CMD_INSERT:
            begin
                if (int'(index) == int'(cmd.pos))
                begin
                    value_next = cmd.value;
                end
                else if (int'(index) > int'(cmd.pos))
                begin
                    value_next = left_value;
                end
            end
            olir_pkg::CMD_REMOVE_AT:
            begin
                if (int'(index) >= int'(cmd.pos))
                begin
                    value_next = right_value;
                end
            end
            olir_pkg::CMD_REMOVE_VAL:
            begin
                if (chain_out.found)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // search flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            pick_reg  <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            pick_reg  <= pick_next;
        end
    end

    assign value = value_reg;

endmodule
